### rtl/dlip_pkg.sv
// Shared types and constants for the decimal line integer parser.
package dlip_pkg;

  localparam int LINE_LIMIT_DEF = 64;

  localparam int VALUE_W = 31;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [VALUE_W-1:0] MAX_VALUE_RST = '1;
  localparam logic [BYTE_W-1:0]  LINE_END_RST  = 8'd10;

  localparam logic [BYTE_W-1:0] SPACE_MAX = 8'd32;
  localparam logic [BYTE_W-1:0] DIGIT_LO  = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_READ  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_STRAY  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VALUE = 1'd0,
    REG_LINE_END  = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [VALUE_W-1:0] max_value;
    logic [BYTE_W-1:0]  line_end_byte;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } res_t;

endpackage

### rtl/decimal_line_integer_parser.sv
// Top level of the decimal line integer parser: input register, parse core, result register.
//
// Usage:
//   Input beats arrive on s_axis: tdata[7:0] is one character of a line, tuser[0]
//   marks end of file (the character is then ignored). Bytes 0..32 are whitespace;
//   one run of digits may stand between leading and trailing whitespace.
//   A beat equal to the configured line end byte, or an end of file beat, yields
//   one result beat on m_axis: tdata[30:0] the value, tuser[1:0] the status
//   (ok, parse error, read error). The value is zero unless the status is ok.
//   All other beats yield nothing. The cfg channel writes the maximum value
//   (index 0) and the line end byte (index 1) and is always ready. The user must
//   see that it is written only while the block is idle; the block does not check.
// Timing:
//   A beat is held in the input register until the core consumes it; the parse
//   step for that beat lands in the result register, so a result passes both
//   registers after its beat is accepted. One beat per cycle is taken while
//   m_axis does not stall; the accumulate-and-compare step on the line state sets that rate.
// Reset and stall:
//   rst clears both registers, the line state and the config registers to
//   their defaults. While m_axis stalls with a result held, the input register
//   fills and then s_axis_tready drops; no beat is lost or duplicated.
module decimal_line_integer_parser #(
  parameter int LINE_LIMIT = dlip_pkg::LINE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]                     s_axis_tuser,   // [0] end_of_file
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // [30:0] value, [31] zero
  output logic [1:0]                     m_axis_tuser,   // [1:0] status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlip_pkg::VALUE_W-1:0]   cfg_data
);
  import dlip_pkg::*;

  cfg_t               cfg;
  res_t               res;
  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               in_eof;
  logic               out_free;
  logic               fire;
  logic [VALUE_W-1:0] out_value;
  status_t            out_status;

  // result register can load when empty or being taken this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  dlip_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlip_parse_core #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_byte),
    .end_of_file (in_eof),
    .cfg         (cfg),
    .res         (res)
  );

  // input register: hold a beat until the core consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eof  <= s_axis_tuser[0];
    end
  end

  // result register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_value  <= res.value;
      out_status <= res.status;
    end
  end

  assign m_axis_tdata = {1'b0, out_value};
  assign m_axis_tuser = out_status;

endmodule

### rtl/dlip_cfg_regs.sv
// Configuration register file: maximum value and line end byte.
module dlip_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlip_pkg::VALUE_W-1:0]    cfg_data,
  output dlip_pkg::cfg_t                  cfg
);
  import dlip_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_value     <= MAX_VALUE_RST;
      cfg.line_end_byte <= LINE_END_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_VALUE: cfg.max_value     <= cfg_data;
        REG_LINE_END:  cfg.line_end_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/dlip_parse_core.sv
// Line state and per-byte parse step; produces the result of a line end or end of file.
module dlip_parse_core #(
  parameter int LINE_LIMIT = dlip_pkg::LINE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [dlip_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          end_of_file,
  input  dlip_pkg::cfg_t                cfg,
  output dlip_pkg::res_t                res
);
  import dlip_pkg::*;

  localparam int CNT_W = $clog2(LINE_LIMIT + 2);
  localparam logic [CNT_W-1:0] LIM    = CNT_W'(LINE_LIMIT);
  localparam logic [CNT_W-1:0] LIM_P1 = CNT_W'(LINE_LIMIT + 1);
  localparam int PROD_W = VALUE_W + 4;

  phase_t             phase, phase_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               too_large, too_large_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;

  logic               is_space, is_digit, is_end, bad;
  logic [PROD_W-1:0]  prod;

  assign is_space = (in_byte <= SPACE_MAX);
  assign is_digit = (in_byte >= DIGIT_LO) && (in_byte <= DIGIT_HI);
  assign is_end   = (in_byte == cfg.line_end_byte);

  // acc * 10 + digit, as two shifted copies and the digit
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
              + PROD_W'(in_byte - DIGIT_LO) ;

  assign bad = (byte_count > LIM) || too_large ||
               (phase == PH_LEAD) || (phase == PH_STRAY);

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    too_large_next  = too_large;
    byte_count_next = byte_count;
    res.valid       = 1'b0;
    res.value       = '0;
    res.status      = ST_OK;
    if (fire) begin
      if (end_of_file || is_end) begin
        res.valid = 1'b1;
        if (end_of_file) begin
          res.status = ST_READ;
        end else if (bad) begin
          res.status = ST_PARSE;
        end else begin
          res.value = acc;
        end
        phase_next      = PH_LEAD;
        acc_next        = '0;
        too_large_next  = 1'b0;
        byte_count_next = '0;
      end else if (byte_count >= LIM) begin
        // past the limit: count saturates, byte is not examined
        byte_count_next = LIM_P1;
      end else begin
        byte_count_next = byte_count + 1'b1;
        case (phase)
          PH_LEAD: begin
            if (!is_space) phase_next = is_digit ? PH_DIGITS : PH_STRAY;
          end
          PH_DIGITS: begin
            if (is_space) phase_next = PH_TRAIL;
            else if (!is_digit) phase_next = PH_STRAY;
          end
          PH_TRAIL: begin
            if (!is_space) phase_next = PH_STRAY;
          end
          default: ;
        endcase
        if (is_digit && !too_large && (phase == PH_LEAD || phase == PH_DIGITS)) begin
          if (prod > PROD_W'(cfg.max_value)) too_large_next = 1'b1;
          else acc_next = prod[VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      acc        <= '0;
      too_large  <= 1'b0;
      byte_count <= '0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      too_large  <= too_large_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

### rtl/dlip_checker.sv
// Port-level checks for the decimal line integer parser, bound to the top level.
module dlip_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import dlip_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_PARSE ||
                       m_axis_tuser == ST_READ))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 32'd0)
    else $error("value not zero on error");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind decimal_line_integer_parser dlip_port_checks u_dlip_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/dlip_checker.sv
// Checker for the decimal line integer parser: predicts results from accepted beats and compares.
module dlip_checker #(
  parameter int LINE_LIMIT = dlip_pkg::LINE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]                     s_axis_tuser,   // [0] end_of_file
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [31:0]                    m_axis_tdata,   // [30:0] value, [31] zero
  input  logic [1:0]                     m_axis_tuser,   // [1:0] status
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dlip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlip_pkg::VALUE_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import dlip_pkg::*;

  localparam int RADIX = 10;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } parse_result_t;

  // Mirror of the configuration registers
  logic [VALUE_W-1:0] max_value;
  logic [BYTE_W-1:0]  line_end;

  // Mirror of the line state
  phase_t             ph;
  logic [VALUE_W-1:0] digits_acc;
  logic               over_max;
  int                 line_bytes;

  parse_result_t expected_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_line();
    ph         = PH_LEAD;
    digits_acc = '0;
    over_max   = 1'b0;
    line_bytes = 0;
  endtask

  task automatic parse_beat(input logic [7:0] b, input logic eof,
                            output logic emit, output parse_result_t res);
    logic        is_space;
    logic        is_digit;
    logic [63:0] nxt;
    is_space   = (b <= SPACE_MAX);
    is_digit   = (b >= DIGIT_LO) && (b <= DIGIT_HI);
    emit       = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (eof) begin
      emit       = 1'b1;
      res.status = ST_READ;
      clear_line();
    end else if (b == line_end) begin
      // line end test comes before any class test of the byte
      emit = 1'b1;
      if (line_bytes > LINE_LIMIT || over_max || ph == PH_LEAD || ph == PH_STRAY)
        res.status = ST_PARSE;
      else
        res.value = digits_acc;
      clear_line();
    end else if (line_bytes >= LINE_LIMIT) begin
      // past the limit: saturate the count, ignore the byte
      line_bytes = LINE_LIMIT + 1;
    end else begin
      line_bytes++;
      case (ph)
        PH_LEAD: begin
          if (!is_space) ph = is_digit ? PH_DIGITS : PH_STRAY;
        end
        PH_DIGITS: begin
          if (is_space) ph = PH_TRAIL;
          else if (!is_digit) ph = PH_STRAY;
        end
        PH_TRAIL: begin
          if (!is_space) ph = PH_STRAY;
        end
        default: ;
      endcase
      if (ph == PH_DIGITS && is_digit && !over_max) begin
        nxt = 64'(digits_acc) * 64'(RADIX) + 64'(b - DIGIT_LO);
        if (nxt > 64'(max_value)) over_max = 1'b1;
        else digits_acc = nxt[VALUE_W-1:0];
      end
    end
  endtask

  always @(posedge clk) begin : watch
    parse_result_t want;
    parse_result_t res;
    logic          emit;
    if (rst) begin
      max_value = MAX_VALUE_RST;
      line_end  = LINE_END_RST;
      clear_line();
      expected_results.delete();
    end else begin
      // result side first: a beat cannot come back in the edge it goes in
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value %0d status %0d",
                                  m_axis_tdata[VALUE_W-1:0], m_axis_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[VALUE_W-1:0] !== want.value)
            flag_mismatch($sformatf("value %0d, want %0d",
                                    m_axis_tdata[VALUE_W-1:0], want.value));
          if (m_axis_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
          if (m_axis_tdata[31] !== 1'b0)
            flag_mismatch("tdata pad bit not zero");
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_beat(s_axis_tdata, s_axis_tuser[0], emit, res);
        if (emit) expected_results.push_back(res);
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_VALUE: max_value = cfg_data;
          REG_LINE_END:  line_end  = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for the decimal line integer parser: stimulus, receiver stalls and verdict.
module tb_top;
  import dlip_pkg::*;

  localparam int LINE_LIMIT    = LINE_LIMIT_DEF;
  localparam int ITEMS_TARGET  = 2000;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    RX_FLOW,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready a quarter of the time
    RX_TOGGLE   // ready half the time, alternating
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;    // [7:0] in_byte
  logic [0:0]           s_axis_tuser = '0;    // [0] end_of_file
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;         // [30:0] value, [31] zero
  logic [1:0]           m_axis_tuser;         // [1:0] status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VALUE_W-1:0]   cfg_data = '0;

  int         fail_count;
  int         outstanding;
  int         items_sent = 0;
  int         burst_left = 0;
  logic       hold_req = 1'b0;
  logic [7:0] cur_line_end = LINE_END_RST;

  decimal_line_integer_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dlip_checker #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: switch between stall patterns at random intervals; on request
  // hold off for a long stretch so the block backs up into its input.
  initial begin : receiver
    rx_mode_t rx_mode;
    int       rx_left;
    logic     rx_flip;
    rx_mode = RX_FLOW;
    rx_left = 0;
    rx_flip = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      rx_flip = ~rx_flip;
      case (rx_mode)
        RX_FLOW:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= rx_flip;
      endcase
    end
  end

  // Offer one beat and hold it until taken. Beats go out in bursts, with valid
  // dropped between bursts. Call and return at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline drain
  // of beats that produce nothing.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers back to back; valid stays high across the two beats.
  task automatic set_config(input logic [VALUE_W-1:0] max_value, input logic [7:0] line_end);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_VALUE;
    cfg_data  <= max_value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_LINE_END;
    cfg_data  <= VALUE_W'(line_end);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_line_end = line_end;
  endtask

  // Whitespace and digits that cannot be mistaken for the line end byte
  function automatic logic [7:0] pick_space();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 32)); while (b == cur_line_end);
    return b;
  endfunction

  function automatic logic [7:0] pick_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(48, 57)); while (b == cur_line_end);
    return b;
  endfunction

  initial begin : stimulus
    int phase_no;
    int phase_end;
    int roll;
    int n;
    int total;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset configuration (line end is newline)
    send_item(8'h00, 1'b0);        // NUL counts as whitespace
    send_text("7 \n");             // ok 7
    send_item(8'hFF, 1'b0);        // high byte is a stray character
    send_text("\n");
    send_text("\n");               // no digits at all
    send_text("1");
    send_item(8'h0A, 1'b1);        // end of file wins over the line end byte
    send_text("1 2\n");            // digit after trailing whitespace
    send_text(":\n");              // just above the digit range

    // Value right at and just above the maximum; line end is a digit
    wait_idle();
    set_config(VALUE_W'(12), 8'h35);
    send_text("125");              // ok 12
    send_text("135");              // too large
    send_item(8'h35, 1'b1);        // end of file with the line end byte

    // Random phases, each under its own configuration
    for (phase_no = 0; items_sent < ITEMS_TARGET; phase_no++) begin
      wait_idle();
      case (phase_no)
        0: set_config(MAX_VALUE_RST, LINE_END_RST);
        1: set_config('0, 8'h00);
        2: set_config(VALUE_W'($urandom_range(1, 99999)), 8'hFF);
        3: set_config(VALUE_W'($urandom), 8'h37);
        4: set_config(MAX_VALUE_RST, SPACE_MAX);
        default: set_config(($urandom_range(0, 1) == 1) ? VALUE_W'($urandom_range(0, 999))
                                                         : VALUE_W'($urandom),
                            8'($urandom_range(0, 255)));
      endcase
      // Long receiver hold-off while the sender keeps offering
      if (phase_no == 2) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
          // well-formed line: whitespace, digits, whitespace, line end
          n = $urandom_range(0, 3);
          repeat (n) send_item(pick_space(), 1'b0);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 4);
          repeat (n) send_item(pick_digit(), 1'b0);
          n = $urandom_range(0, 3);
          repeat (n) send_item(pick_space(), 1'b0);
          send_item(cur_line_end, 1'b0);
        end else if (roll < 80) begin
          // arbitrary bytes, then line end
          n = $urandom_range(1, 8);
          repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
          send_item(cur_line_end, 1'b0);
        end else if (roll < 88) begin
          // length right around the line limit
          total = LINE_LIMIT - 1 + $urandom_range(0, 3);
          n = $urandom_range(1, 4);
          repeat (total - n) send_item(pick_space(), 1'b0);
          repeat (n) send_item(pick_digit(), 1'b0);
          send_item(cur_line_end, 1'b0);
        end else if (roll < 95) begin
          // line cut short by end of file
          n = $urandom_range(0, 5);
          repeat (n) send_item(pick_digit(), 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
